// ----- hdl/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, byte codes and hex digit helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Parse phase of the decoder
  typedef enum logic [2:0] {
    PH_SIZE_FIRST  = 3'd0,
    PH_SIZE_DIGITS = 3'd1,
    PH_SIZE_PAD    = 3'd2,
    PH_DATA        = 3'd3,
    PH_DATA_TAIL   = 3'd4,
    PH_DONE        = 3'd5,
    PH_ERROR       = 3'd6
  } phase_t;

  // Classification of each byte
  typedef enum logic [2:0] {
    K_FRAMING   = 3'd0,
    K_PAYLOAD   = 3'd1,
    K_CHUNK_END = 3'd2,
    K_BODY_END  = 3'd3,
    K_ERROR     = 3'd4,
    K_IGNORED   = 3'd5
  } kind_t;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  // Radix 16: each digit shifts the size by one nibble
  localparam int RADIX_BITS  = 4;
  localparam int TOTAL_BITS  = 40;
  localparam int REPORT_BITS = 63;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [RADIX_BITS-1:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[RADIX_BITS-1:0];
  endfunction

endpackage

// ----- hdl/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips chunked transfer framing from an HTTP body, one byte per item.
// ----------------------------------------------------------------------------
// Takes one body byte per cycle while data_stall is low and returns one
// classified result per byte. Each byte passes through the input register,
// then the result register.
// The parse state (phase, chunk size, bytes left, body length) is updated
// once per byte, so a byte may follow in every cycle unless the result
// register stalls, when the input register lets one byte wait. The
// chunk size saturates at 2^SIZE_BITS - 1 and the body length at 2^40 - 1.
// An error is sticky until a byte with start_of_body set.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   data_valid,
  output logic                   data_stall,
  input  logic [7:0]             data_byte,
  input  logic                   start_of_body,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [2:0]             kind,
  output logic [7:0]             payload_byte,
  output logic [REPORT_BITS-1:0] chunk_len,
  output logic [TOTAL_BITS-1:0]  body_length
);

  localparam logic [SIZE_BITS-1:0]  SIZE_MAX  = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_sob;

  // Parse state
  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  current_size, current_size_next;
  logic [SIZE_BITS-1:0]  bytes_left, bytes_left_next;
  logic [TOTAL_BITS-1:0] payload_total, payload_total_next;

  kind_t      kind_next;
  logic [7:0] pay_next;

  logic advance;
  logic take;
  logic step;

  // Handshake: result register frees when empty or taken
  assign advance    = !result_valid || !result_stall;
  assign data_stall = s1_valid && !advance;
  assign take       = data_valid && !data_stall;
  assign step       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && !advance);
    end
    if (take) begin
      s1_byte <= data_byte;
      s1_sob  <= start_of_body;
    end
  end

  // Per-byte parse step
  always_comb begin
    phase_t                ph;
    logic [SIZE_BITS-1:0]  cs;
    logic [SIZE_BITS-1:0]  bl;
    logic [TOTAL_BITS-1:0] pt;
    logic                  hex;
    logic [RADIX_BITS-1:0] dig;
    logic [SIZE_BITS-1:0]  cs_added;
    logic                  sp_or_cr;

    // start of body clears state before the byte is taken
    ph  = s1_sob ? PH_SIZE_FIRST : phase;
    cs  = s1_sob ? '0 : current_size;
    bl  = s1_sob ? '0 : bytes_left;
    pt  = s1_sob ? '0 : payload_total;
    hex = is_hex(s1_byte);
    dig = hex_digit(s1_byte);
    sp_or_cr = (s1_byte == CH_CR) || (s1_byte == CH_SP);

    // saturating shift-in of one hex digit
    if (|cs[SIZE_BITS-1 -: RADIX_BITS]) begin
      cs_added = SIZE_MAX;
    end else begin
      cs_added = {cs[SIZE_BITS-RADIX_BITS-1:0], dig};
    end

    phase_next         = ph;
    current_size_next  = cs;
    bytes_left_next    = bl;
    payload_total_next = pt;
    kind_next          = K_ERROR;
    pay_next           = 8'h00;

    case (ph)
      PH_SIZE_FIRST: begin
        if (hex) begin
          current_size_next = SIZE_BITS'(dig);
          phase_next        = PH_SIZE_DIGITS;
          kind_next         = K_FRAMING;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_SIZE_DIGITS, PH_SIZE_PAD: begin
        if (hex && ph == PH_SIZE_DIGITS) begin
          current_size_next = cs_added;
          kind_next         = K_FRAMING;
        end else if (sp_or_cr) begin
          phase_next = PH_SIZE_PAD;
          kind_next  = K_FRAMING;
        end else if (s1_byte == CH_LF) begin
          if (cs == '0) begin
            phase_next = PH_DONE;
            kind_next  = K_BODY_END;
          end else begin
            bytes_left_next = cs;
            phase_next      = PH_DATA;
            kind_next       = K_FRAMING;
          end
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DATA: begin
        kind_next = K_PAYLOAD;
        pay_next  = s1_byte;
        if (pt != TOTAL_MAX) begin
          payload_total_next = pt + TOTAL_BITS'(1);
        end
        if (bl != '0) begin
          bytes_left_next = bl - SIZE_BITS'(1);
        end
        // last payload byte when at most one was left
        if (bl[SIZE_BITS-1:1] == '0) begin
          phase_next = PH_DATA_TAIL;
        end
      end
      PH_DATA_TAIL: begin
        if (s1_byte == CH_CR) begin
          kind_next = K_FRAMING;
        end else if (s1_byte == CH_LF) begin
          kind_next  = K_CHUNK_END;
          phase_next = PH_SIZE_FIRST;
        end else begin
          phase_next = PH_ERROR;
        end
      end
      PH_DONE: begin
        kind_next = K_IGNORED;
      end
      default: begin
        phase_next = PH_ERROR;
        kind_next  = K_ERROR;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE_FIRST;
      current_size  <= '0;
      bytes_left    <= '0;
      payload_total <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (step) begin
        phase         <= phase_next;
        current_size  <= current_size_next;
        bytes_left    <= bytes_left_next;
        payload_total <= payload_total_next;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
    end
    if (step) begin
      kind         <= 3'(kind_next);
      payload_byte <= pay_next;
      chunk_len    <= REPORT_BITS'(current_size_next);
      body_length  <= payload_total_next;
    end
  end

  // Checks
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (step && !s1_sob && phase == PH_ERROR) |=> (kind == 3'(K_ERROR)))
    else $error("error phase left without start of body");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("data phase with no bytes left");

  a_total_grows: assert property (@(posedge clk) disable iff (rst)
    (step && !s1_sob) |=> (payload_total >= $past(payload_total)))
    else $error("body length went down within a body");

  a_pay_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != 3'(K_PAYLOAD)) |-> (payload_byte == 8'h00))
    else $error("payload byte set on a non-payload result");

endmodule
